// ===== rtl/imu_rfp_pkg.sv =====
// shared types and constants of the imu rate frame parser
package imu_rfp_pkg;

  localparam int FRAME_BYTES_DEF = 11;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // byte offsets of the rate words inside a frame, low byte first
  localparam int RATE_X_POS = 2;
  localparam int RATE_Y_POS = 4;
  localparam int RATE_Z_POS = 6;

  typedef struct packed {
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
  } rate_res_t;

endpackage

// ===== rtl/imu_rfp_window.sv =====
// sliding byte window, running checksum and frame check
module imu_rfp_window #(
  parameter int FRAME_BYTES = imu_rfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output imu_rfp_pkg::rate_res_t res
);

  localparam int DEPTH  = FRAME_BYTES - 1;
  localparam int FILL_W = $clog2(FRAME_BYTES);

  // only the first FRAME_BYTES-1 bytes are stored; the last byte is the
  // incoming one and is checked against the running sum directly
  logic [7:0]        win_r [DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        sum_r, sum_nxt;

  logic last_byte;
  logic hdr_ok;
  logic frame_ok;

  assign last_byte = (fill_r == FILL_W'(DEPTH));
  assign hdr_ok    = (win_r[0] == imu_rfp_pkg::SYNC_BYTE) &&
                     ((win_r[1] == imu_rfp_pkg::TYPE_ACC) ||
                      (win_r[1] == imu_rfp_pkg::TYPE_RATE) ||
                      (win_r[1] == imu_rfp_pkg::TYPE_ANGLE));
  assign frame_ok  = last_byte && hdr_ok && (sum_r == rx_byte);

  assign res_valid = step_en && frame_ok && (win_r[1] == imu_rfp_pkg::TYPE_RATE);
  assign res.rate_x = {win_r[imu_rfp_pkg::RATE_X_POS + 1], win_r[imu_rfp_pkg::RATE_X_POS]};
  assign res.rate_y = {win_r[imu_rfp_pkg::RATE_Y_POS + 1], win_r[imu_rfp_pkg::RATE_Y_POS]};
  assign res.rate_z = {win_r[imu_rfp_pkg::RATE_Z_POS + 1], win_r[imu_rfp_pkg::RATE_Z_POS]};

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (!last_byte) begin
      fill_nxt = fill_r + 1'b1;
      sum_nxt  = sum_r + rx_byte;
    end else if (frame_ok) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end else begin
      // oldest byte drops out, new byte enters at the top
      sum_nxt = sum_r - win_r[0] + rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else if (step_en) begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      if (!last_byte) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (fill_r == FILL_W'(i)) win_r[i] <= rx_byte;
        end
      end else if (!frame_ok) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[DEPTH-1] <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/imu_rfp_out_stage.sv =====
// output register of the result channel
module imu_rfp_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  imu_rfp_pkg::rate_res_t res,
  output logic                   advance,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata
);

  logic                   out_valid_r;
  imu_rfp_pkg::rate_res_t out_data_r;

  // the upstream stage may move when this register is empty or drains now
  assign advance    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.rate_z, out_data_r.rate_y, out_data_r.rate_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res;
  end

endmodule

// ===== rtl/imu_rate_frame_parser.sv =====
// top level of the imu rate frame parser
//
// in_*: one received sensor byte per beat (in_tdata = rx_byte).
// out_*: one beat per accepted angular rate frame (header 0x55, kind 0x52,
//   8-bit sum of the first ten bytes equal to the eleventh byte).
//   out_tdata packs rate_x, rate_y, rate_z, signed raw counts of
//   2000/32768 deg/s each. acceleration and angle frames are consumed
//   silently, a failed check drops the oldest byte and the scan goes on.
// path: the frame's last byte is held in the input register, then the window
//   step checks it and loads the output register that drives out_tvalid; a
//   stalled output register holds the window step back.
// throughput: one byte per cycle unless a stalled result beat holds the input;
//   with the running checksum held in the window, a byte is one add and one compare.
// a stalled receiver holds the output register; one more byte still
//   enters the input register, after which in_tready drops until the
//   result beat is taken.
// reset (rst_n low, synchronous) empties the window, the checksum and
//   both pipeline registers.
module imu_rate_frame_parser #(
  parameter int FRAME_BYTES = imu_rfp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata    // [15:0] rate_x, [31:16] rate_y, [47:32] rate_z
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       advance;
  logic       step_en;
  logic       res_valid;
  imu_rfp_pkg::rate_res_t res;

  assign in_tready = !s1_valid_r || advance;
  assign step_en   = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_byte_r <= in_tdata;
  end

  imu_rfp_window #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .rx_byte   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  imu_rfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/imu_rfp_checker.sv =====
// port level checks of the imu rate frame parser, bound to the top level
module imu_rfp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // a result beat waits until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // input backpressure only comes from a stalled result beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // a new result always follows a byte beat, through the input register and then the output register
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a byte beat");

endmodule

bind imu_rate_frame_parser imu_rfp_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== verif/tb.sv =====
// self-checking testbench for the imu rate frame parser
`timescale 1ns / 100ps

module tb;

  localparam int FRAME_LEN    = imu_rfp_pkg::FRAME_BYTES_DEF;
  localparam int N_ITEMS      = 1300;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_RATE
  } exp_kind_t;

  typedef struct packed {
    logic [7:0]             rx;
    exp_kind_t              chk;
    imu_rfp_pkg::rate_res_t res;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // sliding byte window of the frame scanner, oldest byte at entry 0
  logic [7:0]  frame_win [FRAME_LEN];
  int          win_fill = 0;

  imu_rfp_pkg::rate_res_t rate_expect_q [$];
  int          err_cnt   = 0;
  int          sent      = 0;
  bit          quiet     = 1'b0;
  int unsigned cycle_cnt = 0;

  localparam imu_rfp_pkg::rate_res_t EXTREME_RATES = '{rate_z: 16'shFFFF,
                                                       rate_y: 16'sh7FFF,
                                                       rate_x: 16'sh8000};

  // rate frame with extreme words, acceleration frame, rate frame with bad sum
  stim_row_t dir_tbl [33] = '{
    '{8'h55, EXP_PREDICT, '0}, '{8'h52, EXP_PREDICT, '0}, '{8'h00, EXP_PREDICT, '0},
    '{8'h80, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0}, '{8'h7F, EXP_PREDICT, '0},
    '{8'hFF, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0}, '{8'h00, EXP_PREDICT, '0},
    '{8'h00, EXP_PREDICT, '0}, '{8'hA3, EXP_RATE, EXTREME_RATES},
    '{8'h55, EXP_PREDICT, '0}, '{8'h51, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0},
    '{8'hFF, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0},
    '{8'hFF, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0}, '{8'hFF, EXP_PREDICT, '0},
    '{8'hFF, EXP_PREDICT, '0}, '{8'h9E, EXP_NONE, '0},
    '{8'h55, EXP_PREDICT, '0}, '{8'h52, EXP_PREDICT, '0}, '{8'h01, EXP_PREDICT, '0},
    '{8'h02, EXP_PREDICT, '0}, '{8'h03, EXP_PREDICT, '0}, '{8'h04, EXP_PREDICT, '0},
    '{8'h05, EXP_PREDICT, '0}, '{8'h06, EXP_PREDICT, '0}, '{8'h07, EXP_PREDICT, '0},
    '{8'h08, EXP_PREDICT, '0}, '{8'hCC, EXP_NONE, '0}
  };

  imu_rate_frame_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (frame_win[k]) frame_win[k] = 8'h00;
  end

  function automatic void slide_window();
    for (int k = 0; k < FRAME_LEN - 1; k++) frame_win[k] = frame_win[k + 1];
    frame_win[FRAME_LEN - 1] = 8'h00;
    win_fill = FRAME_LEN - 1;
  endfunction

  // pushes one byte through the window, returns 1 when a rate frame completes
  function automatic bit parse_rx_byte(input logic [7:0] b,
                                       output imu_rfp_pkg::rate_res_t rates);
    logic [7:0] sum;
    rates = '0;
    if (win_fill >= FRAME_LEN) slide_window();
    frame_win[win_fill] = b;
    win_fill++;
    if (win_fill < FRAME_LEN) return 1'b0;
    sum = 8'h00;
    for (int k = 0; k < FRAME_LEN - 1; k++) sum += frame_win[k];
    if (frame_win[0] == imu_rfp_pkg::SYNC_BYTE &&
        frame_win[1] inside {imu_rfp_pkg::TYPE_ACC, imu_rfp_pkg::TYPE_RATE,
                             imu_rfp_pkg::TYPE_ANGLE} &&
        sum == frame_win[FRAME_LEN - 1]) begin
      bit is_rate;
      is_rate = (frame_win[1] == imu_rfp_pkg::TYPE_RATE);
      if (is_rate) begin
        rates.rate_x = {frame_win[imu_rfp_pkg::RATE_X_POS + 1],
                        frame_win[imu_rfp_pkg::RATE_X_POS]};
        rates.rate_y = {frame_win[imu_rfp_pkg::RATE_Y_POS + 1],
                        frame_win[imu_rfp_pkg::RATE_Y_POS]};
        rates.rate_z = {frame_win[imu_rfp_pkg::RATE_Z_POS + 1],
                        frame_win[imu_rfp_pkg::RATE_Z_POS]};
      end
      foreach (frame_win[k]) frame_win[k] = 8'h00;
      win_fill = 0;
      return is_rate;
    end
    slide_window();
    return 1'b0;
  endfunction

  task automatic feed_byte(input logic [7:0] b, input exp_kind_t chk,
                           input imu_rfp_pkg::rate_res_t typed);
    imu_rfp_pkg::rate_res_t pred;
    bit                     hit;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hit = parse_rx_byte(b, pred);
    sent++;
    if (sent >= N_ITEMS - QUIET_ITEMS) quiet = 1'b1;
    case (chk)
      EXP_PREDICT: begin
        if (hit) rate_expect_q.push_back(pred);
      end
      EXP_RATE: begin
        rate_expect_q.push_back(typed);
      end
      default: ;
    endcase
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed frame, optionally with one flipped bit, cut after n_bytes
  task automatic send_frame(input int n_bytes, input bit flip);
    logic [7:0] frm [FRAME_LEN];
    logic [7:0] sum;
    int         pick;
    int         bit_pos;
    pick = $urandom_range(0, 9);
    frm[0] = imu_rfp_pkg::SYNC_BYTE;
    frm[1] = (pick < 6) ? imu_rfp_pkg::TYPE_RATE :
             (pick < 8) ? imu_rfp_pkg::TYPE_ACC : imu_rfp_pkg::TYPE_ANGLE;
    sum = frm[0] + frm[1];
    for (int k = 2; k < FRAME_LEN - 1; k++) begin
      frm[k] = payload_byte();
      sum += frm[k];
    end
    frm[FRAME_LEN - 1] = sum;
    if (flip) begin
      pick = $urandom_range(0, FRAME_LEN - 1);
      bit_pos = $urandom_range(0, 7);
      frm[pick][bit_pos] = ~frm[pick][bit_pos];
    end
    for (int k = 0; k < n_bytes; k++) feed_byte(frm[k], EXP_PREDICT, '0);
  endtask

  // line noise, with sync and rate kind bytes mixed in to fake headers
  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1: b = imu_rfp_pkg::SYNC_BYTE;
        2:    b = imu_rfp_pkg::TYPE_RATE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      feed_byte(b, EXP_PREDICT, '0);
    end
  endtask

  // receiver stalls in bursts until the quiet tail of the run
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    imu_rfp_pkg::rate_res_t got;
    imu_rfp_pkg::rate_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (rate_expect_q.size() == 0) begin
        $error("unexpected rate beat: x %0d y %0d z %0d",
               got.rate_x, got.rate_y, got.rate_z);
        err_cnt++;
      end else begin
        want = rate_expect_q.pop_front();
        if (got.rate_x !== want.rate_x) begin
          $error("rate_x: expected %0d, got %0d", want.rate_x, got.rate_x);
          err_cnt++;
        end
        if (got.rate_y !== want.rate_y) begin
          $error("rate_y: expected %0d, got %0d", want.rate_y, got.rate_y);
          err_cnt++;
        end
        if (got.rate_z !== want.rate_z) begin
          $error("rate_z: expected %0d, got %0d", want.rate_z, got.rate_z);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tbl[i]) feed_byte(dir_tbl[i].rx, dir_tbl[i].chk, dir_tbl[i].res);
    while (sent < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) send_frame(FRAME_LEN, 1'b0);
      else if (sel < 80) send_frame(FRAME_LEN, 1'b1);
      else if (sel < 90) send_noise();
      else send_frame($urandom_range(1, FRAME_LEN - 1), 1'b0);
    end
    in_tvalid <= 1'b0;
    while (rate_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
